FILE: hw/rtl/kcd_pkg.sv
`timescale 1ns / 1ps
package kcd_pkg;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_ENTRIES_DEF  = 8192;
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 14;
  localparam int WORD_W = 14;
  localparam int VERT_W = 10;
  localparam int CORE_W = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_OFF  = 2'd0,
    CMD_NBR  = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_READ = 2'd3
  } kcd_cmd_t;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    kcd_cmd_t          cmd;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } kcd_req_t;

  typedef struct packed {
    logic              kind;
    logic [VERT_W-1:0] vertex;
    logic [CORE_W-1:0] core;
  } kcd_res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RES,
    S_DG_A, S_DG_B, S_DG_C,
    S_BC,
    S_CN_A, S_CN_B, S_CN_C,
    S_PF_A, S_PF_B,
    S_PL_A, S_PL_B, S_PL_C,
    S_SH_A, S_SH_B,
    S_PE_A, S_PE_B, S_PE_C, S_PE_D, S_PE_J, S_PE_U, S_PE_DU, S_PE_P, S_PE_W, S_PE_X,
    S_MX_A, S_MX_B
  } kcd_state_t;

endpackage

FILE: hw/rtl/kcd_ram.sv
`timescale 1ns / 1ps
module kcd_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/kcd_peel.sv
`timescale 1ns / 1ps
module kcd_peel
  import kcd_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  kcd_req_t in_req,
  output logic     res_valid,
  input  logic     res_ready,
  output kcd_res_t res
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = $clog2(MAX_ENTRIES);
  localparam int EW = $clog2(MAX_ENTRIES + 1);

  kcd_state_t st, st_next;

  logic          off_we;
  logic [CW-1:0] off_waddr, off_raddr;
  logic [WORD_W-1:0] off_wdata, off_rdata;
  logic          nbr_we;
  logic [NW-1:0] nbr_waddr, nbr_raddr;
  logic [VW-1:0] nbr_wdata, nbr_rdata;
  logic          deg_we;
  logic [VW-1:0] deg_waddr, deg_raddr, deg_wdata, deg_rdata;
  logic          ord_we;
  logic [VW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;
  logic          pos_we;
  logic [VW-1:0] pos_waddr, pos_raddr, pos_wdata, pos_rdata;
  logic          bin_we;
  logic [VW-1:0] bin_waddr, bin_raddr;
  logic [CW-1:0] bin_wdata, bin_rdata;

  logic [CW-1:0] n, v, vtotal, start, run_n;
  logic [VW-1:0] top, cur, dv, u, du, pu, pw, w, maxc, newmax;
  logic [EW-1:0] lo, hi, j, off_clamped, span;
  logic          last_v;
  logic [31:0]   word32;

  function automatic logic [EW-1:0] clampe(input logic [WORD_W-1:0] x);
    logic [31:0] x32;
    x32 = 32'(x);
    return (x32 > 32'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : EW'(x32);
  endfunction

  function automatic logic [EW-1:0] dspan(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [31:0] d;
    d = (b > a) ? 32'(b - a) : 32'd0;
    return (d > 32'(MAX_VERTICES - 1)) ? EW'(MAX_VERTICES - 1) : EW'(d);
  endfunction

  assign word32      = 32'(in_req.word);
  assign run_n       = CW'((word32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : word32);
  assign off_clamped = clampe(off_rdata);
  assign span        = dspan(lo, off_clamped);
  assign last_v      = (CW'(v + CW'(1)) == n);
  assign newmax      = (deg_rdata > maxc) ? deg_rdata : maxc;

  kcd_ram #(.DEPTH(MAX_VERTICES + 1), .AW(CW), .DW(WORD_W)) u_off (
    .clk, .we(off_we), .waddr(off_waddr), .wdata(off_wdata), .raddr(off_raddr),
    .rdata(off_rdata));
  kcd_ram #(.DEPTH(MAX_ENTRIES), .AW(NW), .DW(VW)) u_nbr (
    .clk, .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata), .raddr(nbr_raddr),
    .rdata(nbr_rdata));
  kcd_ram #(.DEPTH(MAX_VERTICES), .AW(VW), .DW(VW)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata), .raddr(deg_raddr),
    .rdata(deg_rdata));
  kcd_ram #(.DEPTH(MAX_VERTICES), .AW(VW), .DW(VW)) u_ord (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata), .raddr(ord_raddr),
    .rdata(ord_rdata));
  kcd_ram #(.DEPTH(MAX_VERTICES), .AW(VW), .DW(VW)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata), .raddr(pos_raddr),
    .rdata(pos_rdata));
  kcd_ram #(.DEPTH(MAX_VERTICES), .AW(VW), .DW(CW)) u_bin (
    .clk, .we(bin_we), .waddr(bin_waddr), .wdata(bin_wdata), .raddr(bin_raddr),
    .rdata(bin_rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next   = st;
    in_ready  = (st == S_IDLE);
    res_valid = (st == S_RES);
    off_we = 1'b0; off_waddr = '0; off_wdata = '0; off_raddr = '0;
    nbr_we = 1'b0; nbr_waddr = '0; nbr_wdata = '0; nbr_raddr = '0;
    deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    pos_we = 1'b0; pos_waddr = '0; pos_wdata = '0; pos_raddr = '0;
    bin_we = 1'b0; bin_waddr = '0; bin_wdata = '0; bin_raddr = '0;
    unique case (st)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_req.cmd)
            CMD_OFF: begin
              if (32'(in_req.slot) <= 32'(MAX_VERTICES)) begin
                off_we    = 1'b1;
                off_waddr = CW'(in_req.slot);
                off_wdata = in_req.word;
              end
            end
            CMD_NBR: begin
              if (32'(in_req.slot) < 32'(MAX_ENTRIES) && word32 < 32'(MAX_VERTICES)) begin
                nbr_we    = 1'b1;
                nbr_waddr = NW'(in_req.slot);
                nbr_wdata = VW'(in_req.word);
              end
            end
            CMD_RUN: begin
              st_next = (run_n == '0) ? S_RES : S_DG_A;
            end
            CMD_READ: begin
              if (32'(in_req.slot) < 32'(vtotal)) begin
                deg_raddr = VW'(in_req.slot);
                st_next   = S_RD;
              end else begin
                st_next = S_RES;
              end
            end
            default: st_next = S_IDLE;
          endcase
        end
      end
      S_RD: st_next = S_RES;
      S_RES: begin
        if (res_ready) begin
          st_next = S_IDLE;
        end
      end
      S_DG_A: begin
        off_raddr = v;
        st_next   = S_DG_B;
      end
      S_DG_B: begin
        off_raddr = CW'(v + CW'(1));
        st_next   = S_DG_C;
      end
      S_DG_C: begin
        deg_we    = 1'b1;
        deg_waddr = v[VW-1:0];
        deg_wdata = VW'(span);
        st_next   = last_v ? S_BC : S_DG_A;
      end
      S_BC: begin
        bin_we    = 1'b1;
        bin_waddr = v[VW-1:0];
        st_next   = (v[VW-1:0] == top) ? S_CN_A : S_BC;
      end
      S_CN_A: begin
        deg_raddr = v[VW-1:0];
        st_next   = S_CN_B;
      end
      S_CN_B: begin
        bin_raddr = deg_rdata;
        st_next   = S_CN_C;
      end
      S_CN_C: begin
        bin_we    = 1'b1;
        bin_waddr = dv;
        bin_wdata = CW'(bin_rdata + CW'(1));
        st_next   = last_v ? S_PF_A : S_CN_A;
      end
      S_PF_A: begin
        bin_raddr = v[VW-1:0];
        st_next   = S_PF_B;
      end
      S_PF_B: begin
        bin_we    = 1'b1;
        bin_waddr = v[VW-1:0];
        bin_wdata = start;
        st_next   = (v[VW-1:0] == top) ? S_PL_A : S_PF_A;
      end
      S_PL_A: begin
        deg_raddr = v[VW-1:0];
        st_next   = S_PL_B;
      end
      S_PL_B: begin
        bin_raddr = deg_rdata;
        st_next   = S_PL_C;
      end
      S_PL_C: begin
        pos_we    = 1'b1;
        pos_waddr = v[VW-1:0];
        pos_wdata = bin_rdata[VW-1:0];
        ord_we    = 1'b1;
        ord_waddr = bin_rdata[VW-1:0];
        ord_wdata = v[VW-1:0];
        bin_we    = 1'b1;
        bin_waddr = dv;
        bin_wdata = CW'(bin_rdata + CW'(1));
        st_next   = last_v ? S_SH_A : S_PL_A;
      end
      S_SH_A: begin
        if (v == '0) begin
          bin_we    = 1'b1;
          bin_waddr = '0;
          st_next   = S_PE_A;
        end else begin
          bin_raddr = VW'(v - CW'(1));
          st_next   = S_SH_B;
        end
      end
      S_SH_B: begin
        bin_we    = 1'b1;
        bin_waddr = v[VW-1:0];
        bin_wdata = bin_rdata;
        st_next   = S_SH_A;
      end
      S_PE_A: begin
        ord_raddr = v[VW-1:0];
        st_next   = S_PE_B;
      end
      S_PE_B: begin
        deg_raddr = ord_rdata;
        off_raddr = CW'(ord_rdata);
        st_next   = S_PE_C;
      end
      S_PE_C: begin
        off_raddr = CW'(CW'(cur) + CW'(1));
        st_next   = S_PE_D;
      end
      S_PE_D: st_next = S_PE_J;
      S_PE_J: begin
        if (j == hi) begin
          st_next = last_v ? S_MX_A : S_PE_A;
        end else begin
          nbr_raddr = j[NW-1:0];
          st_next   = S_PE_U;
        end
      end
      S_PE_U: begin
        if (CW'(nbr_rdata) >= n) begin
          st_next = S_PE_J;
        end else begin
          deg_raddr = nbr_rdata;
          st_next   = S_PE_DU;
        end
      end
      S_PE_DU: begin
        if (deg_rdata > dv) begin
          pos_raddr = u;
          bin_raddr = deg_rdata;
          st_next   = S_PE_P;
        end else begin
          st_next = S_PE_J;
        end
      end
      S_PE_P: begin
        ord_raddr = bin_rdata[VW-1:0];
        st_next   = S_PE_W;
      end
      S_PE_W: begin
        bin_we    = 1'b1;
        bin_waddr = du;
        bin_wdata = CW'(CW'(pw) + CW'(1));
        deg_we    = 1'b1;
        deg_waddr = u;
        deg_wdata = VW'(du - VW'(1));
        if (ord_rdata != u) begin
          pos_we    = 1'b1;
          pos_waddr = u;
          pos_wdata = pw;
          ord_we    = 1'b1;
          ord_waddr = pu;
          ord_wdata = ord_rdata;
          st_next   = S_PE_X;
        end else begin
          st_next = S_PE_J;
        end
      end
      S_PE_X: begin
        pos_we    = 1'b1;
        pos_waddr = w;
        pos_wdata = pu;
        ord_we    = 1'b1;
        ord_waddr = pw;
        ord_wdata = u;
        st_next   = S_PE_J;
      end
      S_MX_A: begin
        deg_raddr = v[VW-1:0];
        st_next   = S_MX_B;
      end
      S_MX_B: st_next = last_v ? S_RES : S_MX_A;
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtotal <= '0;
      maxc   <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (in_valid && in_req.cmd == CMD_RUN) begin
            n        <= run_n;
            vtotal   <= run_n;
            v        <= '0;
            top      <= '0;
            maxc     <= '0;
            res.kind <= KIND_RUN;
            res.vertex <= '0;
            res.core <= '0;
          end else if (in_valid && in_req.cmd == CMD_READ) begin
            res.kind   <= KIND_READ;
            res.vertex <= in_req.slot[VERT_W-1:0];
            res.core   <= '0;
          end
        end
        S_RD: res.core <= CORE_W'(deg_rdata);
        S_DG_B: lo <= off_clamped;
        S_DG_C: begin
          if (VW'(span) > top) begin
            top <= VW'(span);
          end
          v <= last_v ? '0 : CW'(v + CW'(1));
        end
        S_BC: begin
          v <= (v[VW-1:0] == top) ? '0 : CW'(v + CW'(1));
        end
        S_CN_B, S_PL_B: dv <= deg_rdata;
        S_CN_C: begin
          v     <= last_v ? '0 : CW'(v + CW'(1));
          start <= '0;
        end
        S_PF_B: begin
          start <= CW'(start + bin_rdata);
          v     <= (v[VW-1:0] == top) ? '0 : CW'(v + CW'(1));
        end
        S_PL_C: v <= last_v ? CW'(top) : CW'(v + CW'(1));
        S_SH_B: v <= CW'(v - CW'(1));
        S_PE_B: cur <= ord_rdata;
        S_PE_C: begin
          dv <= deg_rdata;
          lo <= off_clamped;
        end
        S_PE_D: begin
          hi <= EW'(lo + span);
          j  <= lo;
        end
        S_PE_J: begin
          if (j == hi) begin
            v <= last_v ? '0 : CW'(v + CW'(1));
          end
        end
        S_PE_U: begin
          u <= nbr_rdata;
          if (CW'(nbr_rdata) >= n) begin
            j <= EW'(j + EW'(1));
          end
        end
        S_PE_DU: begin
          du <= deg_rdata;
          if (!(deg_rdata > dv)) begin
            j <= EW'(j + EW'(1));
          end
        end
        S_PE_P: begin
          pu <= pos_rdata;
          pw <= bin_rdata[VW-1:0];
        end
        S_PE_W: begin
          w <= ord_rdata;
          if (ord_rdata == u) begin
            j <= EW'(j + EW'(1));
          end
        end
        S_PE_X: j <= EW'(j + EW'(1));
        S_MX_B: begin
          maxc <= newmax;
          v    <= CW'(v + CW'(1));
          if (last_v) begin
            res.core <= CORE_W'(newmax);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res_valid)
    else $error("input taken while a result is pending");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    st == S_DG_A |-> n != '0)
    else $error("degree pass started on an empty graph");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_vtotal_bound: assert property (@(posedge clk) disable iff (rst)
    32'(vtotal) <= 32'(MAX_VERTICES))
    else $error("vertex total out of range");

endmodule

FILE: hw/rtl/kcore_decomposition_top.sv
`timescale 1ns / 1ps
// k-core decomposition engine.
// Input beats on s_*: s_tuser is the command (offset write, neighbor write, run, core read),
// s_tdata carries slot and word. Output beats on m_*: m_tuser tells a run result from a
// read answer, m_tdata carries vertex and core.
// Offset and neighbor writes are taken one per cycle while the engine is idle and give no
// output beat. A core read passes through S_RD and S_RES to the output register (a vertex
// outside the last run skips S_RD); the next input beat is taken once back in S_IDLE.
// A run walks the stored graph with one shared read/write step per cycle on six RAMs.
// Its passes run in this order: degrees, clearing the degree bins, counting, summing the
// bin starts, placing, shifting the bin starts, peeling, and the maximum. The result then
// waits in S_RES until the output register takes it. s_tready stays low for the whole run.
// The result sits in an output register; when the receiver stalls, the engine holds its
// next result and stays busy, so s_tready stays low, for writes too, until it frees.
// Reset clears the control state and the vertex total, so a read before the first run
// answers core 0. Graph storage is not cleared by reset.
module kcore_decomposition_top
  import kcd_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // slot[13:0], word[27:14], zero
  input  logic [1:0]  s_tuser,  // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // vertex[9:0], core[19:10], zero
  output logic        m_tuser   // kind[0]
);

  kcd_req_t req;
  kcd_res_t res, res_q;
  logic     res_valid, res_ready;

  assign req.cmd  = kcd_cmd_t'(s_tuser);
  assign req.slot = s_tdata[SLOT_W-1:0];
  assign req.word = s_tdata[SLOT_W+WORD_W-1:SLOT_W];

  kcd_peel #(.MAX_VERTICES(MAX_VERTICES), .MAX_ENTRIES(MAX_ENTRIES)) u_peel (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req(req),
    .res_valid, .res_ready, .res);

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {4'd0, res_q.core, res_q.vertex};
  assign m_tuser = res_q.kind;

endmodule
